// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bsrf_pkg.sv =====
// ---------------------------------------------------------------------------
// bsrf_pkg
// types, opcodes and helpers for the byte stream ring fifo
// ---------------------------------------------------------------------------
package bsrf_pkg;

	localparam int DEPTH  = 1024;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CFG_W  = 11;
	localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int TOT_W  = 32;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] write_byte;
	} op_t;

	typedef struct packed {
		logic [7:0]       data_out;
		logic             data_valid;
		logic             accepted;
		logic [CFG_W-1:0] stored_count;
		logic [CFG_W-1:0] room_left;
		logic             input_closed;
		logic             end_of_stream;
		logic [TOT_W-1:0] total_in;
		logic [TOT_W-1:0] total_out;
	} res_t;

	// result fields known at issue; the byte follows from the ram
	typedef struct packed {
		logic             data_valid;
		logic             accepted;
		logic [CFG_W-1:0] stored_count;
		logic [CFG_W-1:0] room_left;
		logic             input_closed;
		logic             end_of_stream;
		logic [TOT_W-1:0] total_in;
		logic [TOT_W-1:0] total_out;
	} stat_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== rtl/bsrf_ram.sv =====
// ---------------------------------------------------------------------------
// bsrf_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module bsrf_ram #(
	parameter int DATA_W  = 8,
	parameter int DEPTH_P = 1024,
	localparam int ADDR_W = $clog2(DEPTH_P)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bsrf_ctrl.sv =====
// ---------------------------------------------------------------------------
// bsrf_ctrl
// pointers, count, flags and totals; decodes each request into ram accesses
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsrf_ctrl import bsrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  op_t              op,
	input  logic             cfg_valid,
	input  logic [CFG_W-1:0] cfg_data,
	output mem_req_t         mem_req,
	output stat_t            stat
);

	logic [CFG_W-1:0] cap_q;
	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic             closed_q, closed_n;
	logic [TOT_W-1:0] tin_q, tin_n, tout_q, tout_n;

	logic [WIDE_W-1:0] cap_wide;
	logic [CNT_W-1:0]  cap;
	logic [CNT_W-1:0]  room;
	logic              valid, acc, we, re;

	// capacity clamped to one up to the built depth
	always_comb begin
		if (cap_q == '0) begin
			cap_wide = WIDE_W'(1);
		end else if (WIDE_W'(cap_q) > WIDE_W'(DEPTH)) begin
			cap_wide = WIDE_W'(DEPTH);
		end else begin
			cap_wide = WIDE_W'(cap_q);
		end
		cap = CNT_W'(cap_wide);
	end

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		closed_n = closed_q;
		tin_n    = tin_q;
		tout_n   = tout_q;
		valid    = 1'b0;
		acc      = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		case (op.opcode)
			OP_WRITE: begin
				if (!closed_q && count_q < cap) begin
					we      = 1'b1;
					acc     = 1'b1;
					tail_n  = ptr_next(tail_q);
					count_n = count_q + CNT_W'(1);
					tin_n   = tin_q + TOT_W'(1);
				end
			end
			OP_READ, OP_PEEK: begin
				if (count_q != '0) begin
					re    = 1'b1;
					valid = 1'b1;
					acc   = 1'b1;
					if (op.opcode == OP_READ) begin
						head_n  = ptr_next(head_q);
						count_n = count_q - CNT_W'(1);
						tout_n  = tout_q + TOT_W'(1);
					end
				end
			end
			OP_END: begin
				closed_n = 1'b1;
				acc      = 1'b1;
			end
			default: begin
			end
		endcase
		room = (count_n < cap) ? cap - count_n : '0;
	end

	always_comb begin
		mem_req.we    = accept && we;
		mem_req.waddr = tail_q;
		mem_req.wdata = op.write_byte;
		mem_req.re    = accept && re;
		mem_req.raddr = head_q;

		stat.data_valid    = valid;
		stat.accepted      = acc;
		stat.stored_count  = CFG_W'(count_n);
		stat.room_left     = CFG_W'(room);
		stat.input_closed  = closed_n;
		stat.end_of_stream = closed_n && (count_n == '0);
		stat.total_in      = tin_n;
		stat.total_out     = tout_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			tin_q    <= '0;
			tout_q   <= '0;
		end else if (accept) begin
			head_q   <= head_n;
			tail_q   <= tail_n;
			count_q  <= count_n;
			closed_q <= closed_n;
			tin_q    <= tin_n;
			tout_q   <= tout_n;
		end
	end

	`ASSERT_CLK(a_count_in_range, count_q <= CNT_W'(DEPTH), "held count beyond depth")
	`ASSERT_CLK(a_empty_ptrs, (count_q == '0) |-> (head_q == tail_q), "empty but pointers differ")
	`ASSERT_CLK(a_full_ptrs, (count_q == CNT_W'(DEPTH)) |-> (head_q == tail_q),
		"full but pointers differ")

endmodule

// ===== rtl/byte_stream_ring_fifo.sv =====
// ---------------------------------------------------------------------------
// byte_stream_ring_fifo
// circular byte fifo with programmable capacity and an end-of-input mark
// ---------------------------------------------------------------------------
// Requests arrive on op (op_valid/op_ready): write a byte, read and pop the
// head byte, peek at the head byte, or end input. Each request yields one
// response on res (res_valid/res_ready) with the byte, count, room, flags and
// 32-bit running totals of bytes written and read.
// The capacity register is written on cfg (cfg_valid/cfg_data, always ready);
// the user must write it only while the block is idle; the block itself does
// not enforce this. It resets to 1024 and is clamped to 1..1024. A request
// passes the byte ram's registered read (ram read stage), then the output
// register. One request is taken every cycle while res is not stalled; the
// single ram write port and read port carry one push or one pop per cycle.
// A stalled receiver holds the output register; one further request is taken
// into the ram read stage, after which op_ready drops until res is drained.
// Reset clears pointers, count, closed flag and totals at once; the byte ram
// itself is not cleared, as no byte is read before it has been written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_stream_ring_fifo import bsrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  op_t              op,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	mem_req_t   mem_req;
	stat_t      stat;
	logic [7:0] rd_data;
	stat_t      stat_s1;
	logic       valid_s1;
	res_t       res_q;
	logic       res_valid_q;
	logic       adv, accept;

	assign adv       = !res_valid_q || res_ready;
	assign op_ready  = !valid_s1 || adv;
	assign accept    = op_valid && op_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	bsrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.mem_req   (mem_req),
		.stat      (stat)
	);

	bsrf_ram #(
		.DATA_W  (8),
		.DEPTH_P (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// ram read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= stat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q.data_out      <= stat_s1.data_valid ? rd_data : 8'd0;
			res_q.data_valid    <= stat_s1.data_valid;
			res_q.accepted      <= stat_s1.accepted;
			res_q.stored_count  <= stat_s1.stored_count;
			res_q.room_left     <= stat_s1.room_left;
			res_q.input_closed  <= stat_s1.input_closed;
			res_q.end_of_stream <= stat_s1.end_of_stream;
			res_q.total_in      <= stat_s1.total_in;
			res_q.total_out     <= stat_s1.total_out;
		end
	end

	`ASSERT_CLK(a_accept_fills_s1, accept |=> valid_s1, "accepted request lost")
	`ASSERT_CLK(a_no_accept_stalled, (valid_s1 && !adv) |-> !op_ready,
		"request taken over a stalled stage")
	`ASSERT_CLK(a_rd_hold, (valid_s1 && stat_s1.data_valid && !adv) |=> $stable(rd_data),
		"ram data changed while stalled")

endmodule
